// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker of the merger.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsm_pkg.sv =====
// Package of the timestamp stream merger: field widths, codes and word types.
// No dependencies; used by the interfaces, every module and the checker.
`default_nettype none

package tsm_pkg;

  localparam int NumSourcesDef = 8;

  localparam int TsW     = 64;
  localparam int OidW    = 16;
  localparam int PayW    = 32;
  localparam int SrcW    = 3;
  localparam int StatusW = 3;
  localparam int ReqW    = 2;
  localparam int CfgW    = 4;

  localparam logic [CfgW-1:0] ActiveReset = 4'd8;

  // request codes
  localparam logic [ReqW-1:0] REQ_OFFER = 2'd0;
  localparam logic [ReqW-1:0] REQ_CLOSE = 2'd1;
  localparam logic [ReqW-1:0] REQ_POP   = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_STORED   = 3'd0;
  localparam logic [StatusW-1:0] ST_BUSY     = 3'd1;
  localparam logic [StatusW-1:0] ST_DECREASE = 3'd2;
  localparam logic [StatusW-1:0] ST_CLOSED   = 3'd3;
  localparam logic [StatusW-1:0] ST_RECORD   = 3'd4;
  localparam logic [StatusW-1:0] ST_WAITING  = 3'd5;
  localparam logic [StatusW-1:0] ST_DRAINED  = 3'd6;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [SrcW-1:0] source;
    logic [TsW-1:0]  ts;
    logic [OidW-1:0] oid;
    logic [PayW-1:0] pay;
  } req_t;

  typedef struct packed {
    logic [TsW-1:0]  ts;
    logic [OidW-1:0] oid;
    logic [PayW-1:0] pay;
  } rec_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TsW-1:0]     ts;
    logic [OidW-1:0]    oid;
    logic [SrcW-1:0]    src;
    logic [PayW-1:0]    pay;
    logic               all_done;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/tsm_ifs.sv =====
// Channel interfaces of the merger: request, response and configuration write.
// Depends on tsm_pkg for the field widths.
`default_nettype none

interface tsm_req_if;
  logic                       valid;
  logic                       ready;
  logic [tsm_pkg::ReqW-1:0]   req_type;
  logic [tsm_pkg::SrcW-1:0]   in_source;
  logic [tsm_pkg::TsW-1:0]    in_timestamp;
  logic [tsm_pkg::OidW-1:0]   in_origin_id;
  logic [tsm_pkg::PayW-1:0]   in_payload;

  modport source (output valid, req_type, in_source, in_timestamp, in_origin_id,
                  in_payload, input ready);
  modport sink   (input valid, req_type, in_source, in_timestamp, in_origin_id,
                  in_payload, output ready);
endinterface

interface tsm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tsm_pkg::StatusW-1:0]  status;
  logic [tsm_pkg::TsW-1:0]      out_timestamp;
  logic [tsm_pkg::OidW-1:0]     out_origin_id;
  logic [tsm_pkg::SrcW-1:0]     out_source;
  logic [tsm_pkg::PayW-1:0]     out_payload;
  logic                         all_done;

  modport source (output valid, status, out_timestamp, out_origin_id, out_source,
                  out_payload, all_done, input ready);
  modport sink   (input valid, status, out_timestamp, out_origin_id, out_source,
                  out_payload, all_done, output ready);
endinterface

interface tsm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tsm_pkg::CfgW-1:0]   active_sources;

  modport source (output valid, active_sources, input ready);
  modport sink   (input valid, active_sources, output ready);
endinterface

`default_nettype wire

// ===== sv/tsm_cmp.sv =====
// Shared key comparator: timestamp first, origin id second.
// Depends on tsm_pkg for the key widths.
`default_nettype none

module tsm_cmp (
  input  logic [tsm_pkg::TsW-1:0]  a_ts_i,
  input  logic [tsm_pkg::OidW-1:0] a_oid_i,
  input  logic [tsm_pkg::TsW-1:0]  b_ts_i,
  input  logic [tsm_pkg::OidW-1:0] b_oid_i,
  output logic                     lt_o
);

  assign lt_o = (a_ts_i != b_ts_i) ? (a_ts_i < b_ts_i) : (a_oid_i < b_oid_i);

endmodule

`default_nettype wire

// ===== sv/tsm_core.sv =====
// Merger sequencer: slot flags, slot and last-timestamp memories, pop scan.
// Depends on tsm_pkg and instantiates tsm_cmp.
`default_nettype none

module tsm_core #(
  parameter int NUM_SOURCES = tsm_pkg::NumSourcesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tsm_pkg::CfgW-1:0] active_i,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  tsm_pkg::req_t            req_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output tsm_pkg::rsp_t            rsp_o
);

  localparam int IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CntW = $clog2(NUM_SOURCES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_OFFER = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [CntW-1:0]        n_act;
  logic [NUM_SOURCES-1:0] act_mask;
  logic [NUM_SOURCES-1:0] full_q, full_d, seen_q, seen_d, closed_q, closed_d;
  logic                   ready_all, any_full, done_now;

  logic [IdxW+tsm_pkg::SrcW-1:0] src_in_wide, src_q_wide;
  logic [IdxW-1:0]               src_in_idx, src_idx;
  logic                          src_in_act;

  logic [tsm_pkg::SrcW-1:0] src_q;
  logic [tsm_pkg::TsW-1:0]  ts_q;
  logic [tsm_pkg::OidW-1:0] oid_q;
  logic [tsm_pkg::PayW-1:0] pay_q;
  logic                     act_ok_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] cnt_idx;
  logic            iss_q, iss_d;

  tsm_pkg::rec_t   rd_rec_q;
  logic            rd_full_q;
  logic [IdxW-1:0] rd_idx_q;

  tsm_pkg::rec_t   best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            best_found_q, best_found_d;
  logic [IdxW+tsm_pkg::SrcW-1:0] best_wide;

  logic [tsm_pkg::TsW-1:0] last_rd_q;
  logic                    mem_we;
  logic                    accept;

  tsm_pkg::rsp_t res_q, res_d;

  tsm_pkg::rec_t           rec_mem  [NUM_SOURCES];
  logic [tsm_pkg::TsW-1:0] last_mem [NUM_SOURCES];

  logic [tsm_pkg::TsW-1:0]  cmp_a_ts, cmp_b_ts;
  logic [tsm_pkg::OidW-1:0] cmp_a_oid, cmp_b_oid;
  logic                     cmp_lt;

  // clamp the register into 1..NUM_SOURCES
  always_comb begin
    if (active_i == '0) begin
      n_act = CntW'(1);
    end else if (32'(active_i) > 32'(NUM_SOURCES)) begin
      n_act = CntW'(NUM_SOURCES);
    end else begin
      n_act = CntW'(active_i);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      act_mask[i] = (CntW'(i) < n_act);
    end
  end

  assign ready_all = &(full_q | closed_q | ~act_mask);
  assign any_full  = |(full_q & act_mask);
  assign done_now  = ~|((full_q | ~closed_q) & act_mask);

  assign src_in_wide = {{IdxW{1'b0}}, req_i.source};
  assign src_in_idx  = src_in_wide[IdxW-1:0];
  assign src_in_act  = (32'(req_i.source) < 32'(n_act));
  assign src_q_wide  = {{IdxW{1'b0}}, src_q};
  assign src_idx     = src_q_wide[IdxW-1:0];
  assign cnt_idx     = cnt_q[IdxW-1:0];
  assign best_wide   = {{tsm_pkg::SrcW{1'b0}}, best_idx_q};

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign accept      = req_valid_i && req_ready_o;

  // one comparator: decrease check on offers, ordering during the scan
  always_comb begin
    if (state_q == S_SCAN) begin
      cmp_a_ts  = rd_rec_q.ts;
      cmp_a_oid = rd_rec_q.oid;
      cmp_b_ts  = best_q.ts;
      cmp_b_oid = best_q.oid;
    end else begin
      cmp_a_ts  = ts_q;
      cmp_a_oid = '0;
      cmp_b_ts  = last_rd_q;
      cmp_b_oid = '0;
    end
  end

  tsm_cmp u_cmp (
    .a_ts_i  (cmp_a_ts),
    .a_oid_i (cmp_a_oid),
    .b_ts_i  (cmp_b_ts),
    .b_oid_i (cmp_b_oid),
    .lt_o    (cmp_lt)
  );

  always_comb begin
    state_d      = state_q;
    full_d       = full_q;
    seen_d       = seen_q;
    closed_d     = closed_q;
    cnt_d        = cnt_q;
    iss_d        = iss_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    best_found_d = best_found_q;
    res_d        = res_q;
    mem_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d          = '0;
          res_d.status   = tsm_pkg::ST_WAITING;
          state_d        = S_RESP;
          case (req_i.req_type)
            tsm_pkg::REQ_OFFER: begin
              state_d = S_OFFER;
            end
            tsm_pkg::REQ_CLOSE: begin
              if (src_in_act) begin
                closed_d[src_in_idx] = 1'b1;
              end
              res_d.status = tsm_pkg::ST_CLOSED;
            end
            tsm_pkg::REQ_POP: begin
              if (!ready_all) begin
                res_d.status = tsm_pkg::ST_WAITING;
              end else if (!any_full) begin
                res_d.status = tsm_pkg::ST_DRAINED;
              end else begin
                state_d      = S_SCAN;
                cnt_d        = '0;
                iss_d        = 1'b0;
                best_found_d = 1'b0;
              end
            end
            default: begin
              res_d.status = tsm_pkg::ST_WAITING;
            end
          endcase
        end
      end

      S_OFFER: begin
        state_d = S_RESP;
        if (!act_ok_q || closed_q[src_idx]) begin
          res_d.status = tsm_pkg::ST_CLOSED;
        end else if (full_q[src_idx]) begin
          res_d.status = tsm_pkg::ST_BUSY;
        end else if (seen_q[src_idx] && cmp_lt) begin
          res_d.status = tsm_pkg::ST_DECREASE;
        end else begin
          full_d[src_idx] = 1'b1;
          seen_d[src_idx] = 1'b1;
          mem_we          = 1'b1;
          res_d.status    = tsm_pkg::ST_STORED;
        end
      end

      S_SCAN: begin
        // ties keep the earlier slot, since slots arrive in ascending order
        if (iss_q && rd_full_q && (!best_found_q || cmp_lt)) begin
          best_d       = rd_rec_q;
          best_idx_d   = rd_idx_q;
          best_found_d = 1'b1;
        end
        if (cnt_q < n_act) begin
          iss_d = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end else begin
          iss_d = 1'b0;
          if (!iss_q) begin
            full_d[best_idx_q] = 1'b0;
            res_d.status       = tsm_pkg::ST_RECORD;
            res_d.ts           = best_q.ts;
            res_d.oid          = best_q.oid;
            res_d.pay          = best_q.pay;
            res_d.src          = best_wide[tsm_pkg::SrcW-1:0];
            state_d            = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      full_q       <= '0;
      seen_q       <= '0;
      closed_q     <= '0;
      cnt_q        <= '0;
      iss_q        <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      full_q       <= full_d;
      seen_q       <= seen_d;
      closed_q     <= closed_d;
      cnt_q        <= cnt_d;
      iss_q        <= iss_d;
      best_found_q <= best_found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q    <= req_i.source;
      ts_q     <= req_i.ts;
      oid_q    <= req_i.oid;
      pay_q    <= req_i.pay;
      act_ok_q <= src_in_act;
    end
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    rd_full_q  <= full_q[cnt_idx];
    rd_idx_q   <= cnt_idx;
  end

  // slot memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[src_idx]  <= '{ts: ts_q, oid: oid_q, pay: pay_q};
      last_mem[src_idx] <= ts_q;
    end
    rd_rec_q  <= rec_mem[cnt_idx];
    last_rd_q <= last_mem[src_in_idx];
  end

  always_comb begin
    rsp_o          = res_q;
    rsp_o.all_done = done_now;
  end

endmodule

`default_nettype wire

// ===== sv/timestamp_stream_merger_top.sv =====
// Top level of the timestamp stream merger: config register, output register, core.
// Depends on tsm_pkg, tsm_ifs and tsm_core.
`default_nettype none

// Merges records from up to NUM_SOURCES sources, one buffered slot each, into one
// stream ordered by timestamp, then origin id, then slot index. Every request
// word gets exactly one response word. The block works on one request at a time
// and drops ready until its response sits in the output register. An offer first
// reads the source's last timestamp from memory, then checks it; a pop that finds
// every active source buffered or closed walks the slots of every active source
// with a single comparator, one slot per cycle through its one read port.
// A refused pop (waiting or drained), a close or an unused code is answered
// without a scan. The response register lets the next request be accepted while
// the last response is still unclaimed.
// Write active_sources only while no request is in flight.
module timestamp_stream_merger_top #(
  parameter int NUM_SOURCES = tsm_pkg::NumSourcesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsm_req_if.sink    req_i,
  tsm_rsp_if.source  rsp_o,
  tsm_cfg_if.sink    cfg_i
);

  logic [tsm_pkg::CfgW-1:0] active_q;

  tsm_pkg::req_t req;
  tsm_pkg::rsp_t core_rsp;
  logic          core_rsp_valid, core_rsp_ready;

  logic          out_valid_q;
  tsm_pkg::rsp_t out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= tsm_pkg::ActiveReset;
    end else if (cfg_i.valid) begin
      active_q <= cfg_i.active_sources;
    end
  end

  assign req.req_type = req_i.req_type;
  assign req.source   = req_i.in_source;
  assign req.ts       = req_i.in_timestamp;
  assign req.oid      = req_i.in_origin_id;
  assign req.pay      = req_i.in_payload;

  tsm_core #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .active_i    (active_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .rsp_valid_o (core_rsp_valid),
    .rsp_ready_i (core_rsp_ready),
    .rsp_o       (core_rsp)
  );

  // load the output register when empty or being emptied
  assign core_rsp_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_rsp_ready) begin
      out_valid_q <= core_rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_rsp_ready && core_rsp_valid) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.out_timestamp = out_q.ts;
  assign rsp_o.out_origin_id = out_q.oid;
  assign rsp_o.out_source    = out_q.src;
  assign rsp_o.out_payload   = out_q.pay;
  assign rsp_o.all_done      = out_q.all_done;

endmodule

`default_nettype wire

// ===== sv/tsm_checker.sv =====
// Port-level checker of the merger and its bind to the top level.
// Depends on tsm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [tsm_pkg::StatusW-1:0]   rsp_status_i,
  input logic [tsm_pkg::TsW-1:0]       rsp_ts_i,
  input logic [tsm_pkg::OidW-1:0]      rsp_oid_i,
  input logic [tsm_pkg::SrcW-1:0]      rsp_src_i,
  input logic [tsm_pkg::PayW-1:0]      rsp_pay_i,
  input logic                          rsp_all_done_i
);

  // one request in flight at a time
  `ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i,
               "request accepted while the previous one is still in flight")

  `ASSERT_IMPLIES(a_zero_unless_record,
                  rsp_valid_i && rsp_status_i != tsm_pkg::ST_RECORD,
                  rsp_ts_i == '0 && rsp_oid_i == '0 && rsp_src_i == '0 && rsp_pay_i == '0,
                  "record fields set on a response without a record")

  `ASSERT_IMPLIES(a_stored_not_done, rsp_valid_i && rsp_status_i == tsm_pkg::ST_STORED,
                  !rsp_all_done_i, "all_done reported right after a record was stored")

  `ASSERT_IMPLIES(a_drained_done, rsp_valid_i && rsp_status_i == tsm_pkg::ST_DRAINED,
                  rsp_all_done_i, "drained reported while all_done is low")

  `ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
               rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_ts_i)
               && $stable(rsp_src_i) && $stable(rsp_all_done_i),
               "stalled response word changed")

endmodule

bind timestamp_stream_merger_top tsm_checker u_tsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_ts_i       (rsp_o.out_timestamp),
  .rsp_oid_i      (rsp_o.out_origin_id),
  .rsp_src_i      (rsp_o.out_source),
  .rsp_pay_i      (rsp_o.out_payload),
  .rsp_all_done_i (rsp_o.all_done)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the timestamp stream merger: directed and random request words,
// response checking against a built-in merge predictor, active_sources sweeps, backpressure.
// Depends on tsm_pkg, tsm_ifs and timestamp_stream_merger_top.

module tb_top;
  import tsm_pkg::*;

  localparam int NumSrc       = NumSourcesDef;
  localparam int SettleCycles = 16;
  localparam int StallLimit   = 4000;
  localparam int MaxReports   = 10;
  localparam int HoldOffLen   = 400;

  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  tsm_req_if req_if ();
  tsm_rsp_if rsp_if ();
  tsm_cfg_if cfg_if ();

  timestamp_stream_merger_top #(
    .NUM_SOURCES(NumSrc)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Merge predictor state: one buffered slot per source plus per-source order history.
  logic [CfgW-1:0] act_reg = ActiveReset;
  bit              held     [NumSrc] = '{default: 1'b0};
  bit              seen     [NumSrc] = '{default: 1'b0};
  bit              closed   [NumSrc] = '{default: 1'b0};
  logic [TsW-1:0]  held_ts  [NumSrc] = '{default: '0};
  logic [OidW-1:0] held_oid [NumSrc] = '{default: '0};
  logic [PayW-1:0] held_pay [NumSrc] = '{default: '0};
  logic [TsW-1:0]  last_ts  [NumSrc] = '{default: '0};

  rsp_t merge_rsp_q[$];

  int fail_count   = 0;
  int req_words    = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;
  int status_hits [8] = '{default: 0};

  int req_gap_pct = 19;
  int rsp_gap_pct = 19;
  int hold_ask    = 0;
  int hold_serial = 0;

  logic [OidW-1:0] oid_corner [3] = '{16'h0000, 16'h0001, 16'hffff};

  function automatic int live_count();
    int n;
    n = act_reg;
    if (n < 1) n = 1;
    if (n > NumSrc) n = NumSrc;
    return n;
  endfunction

  function automatic bit orders_first(int a, int b);
    if (held_ts[a] != held_ts[b]) return held_ts[a] < held_ts[b];
    if (held_oid[a] != held_oid[b]) return held_oid[a] < held_oid[b];
    return a < b;
  endfunction

  function automatic rsp_t merge_predict(req_t w);
    rsp_t r;
    int   n;
    int   s;
    int   best;
    bit   all_in;
    bit   found;
    r = '0;
    r.status = ST_WAITING;
    n = live_count();
    s = w.source;
    case (w.req_type)
      REQ_OFFER: begin
        if (s >= n || closed[s]) begin
          r.status = ST_CLOSED;
        end else if (held[s]) begin
          r.status = ST_BUSY;
        end else if (seen[s] && w.ts < last_ts[s]) begin
          r.status = ST_DECREASE;
        end else begin
          held[s]     = 1'b1;
          held_ts[s]  = w.ts;
          held_oid[s] = w.oid;
          held_pay[s] = w.pay;
          last_ts[s]  = w.ts;
          seen[s]     = 1'b1;
          r.status    = ST_STORED;
        end
      end
      REQ_CLOSE: begin
        if (s < n) closed[s] = 1'b1;
        r.status = ST_CLOSED;
      end
      REQ_POP: begin
        all_in = 1'b1;
        found  = 1'b0;
        best   = 0;
        for (int i = 0; i < n; i++) begin
          if (held[i]) begin
            if (!found || orders_first(i, best)) begin
              best  = i;
              found = 1'b1;
            end
          end else if (!closed[i]) begin
            all_in = 1'b0;
          end
        end
        if (!all_in) begin
          r.status = ST_WAITING;
        end else if (!found) begin
          r.status = ST_DRAINED;
        end else begin
          r.status   = ST_RECORD;
          r.ts       = held_ts[best];
          r.oid      = held_oid[best];
          r.src      = SrcW'(best);
          r.pay      = held_pay[best];
          held[best] = 1'b0;
        end
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++)
      if (held[i] || !closed[i]) r.all_done = 1'b0;
    return r;
  endfunction

  // Sample all channels at the rising edge; check the response before logging a new request.
  always @(posedge clk_i) begin : monitor
    rsp_t got;
    rsp_t want;
    req_t w;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status   = rsp_if.status;
        got.ts       = rsp_if.out_timestamp;
        got.oid      = rsp_if.out_origin_id;
        got.src      = rsp_if.out_source;
        got.pay      = rsp_if.out_payload;
        got.all_done = rsp_if.all_done;
        status_hits[got.status]++;
        if (merge_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("error: response word with nothing outstanding, status %0d", got.status);
        end else begin
          want = merge_rsp_q.pop_front();
          if (got.status !== want.status || got.ts !== want.ts || got.oid !== want.oid ||
              got.src !== want.src || got.pay !== want.pay || got.all_done !== want.all_done)
          begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("mismatch at %0t: exp status %0d ts %h oid %h src %0d pay %h done %b",
                       $realtime, want.status, want.ts, want.oid, want.src, want.pay,
                       want.all_done);
              $display("                 got status %0d ts %h oid %h src %0d pay %h done %b",
                       got.status, got.ts, got.oid, got.src, got.pay, got.all_done);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        w.req_type = req_if.req_type;
        w.source   = req_if.in_source;
        w.ts       = req_if.in_timestamp;
        w.oid      = req_if.in_origin_id;
        w.pay      = req_if.in_payload;
        merge_rsp_q.push_back(merge_predict(w));
        req_words++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        act_reg = cfg_if.active_sources;
        cfg_writes++;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timestamp_stream_merger_top regression: fail");
        $finish;
      end
    end
  end

  function automatic bit gap_draw(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver: random ready, or a long hold-off when the test asks for one.
  initial begin
    int hold_left;
    int seen_serial;
    hold_left   = 0;
    seen_serial = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_serial != seen_serial) begin
        seen_serial = hold_serial;
        hold_left   = hold_ask;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !gap_draw(rsp_gap_pct);
      end
    end
  end

  function automatic req_t req_word(logic [ReqW-1:0] kind, logic [SrcW-1:0] src,
                                    logic [TsW-1:0] ts, logic [OidW-1:0] oid,
                                    logic [PayW-1:0] pay);
    req_t w;
    w.req_type = kind;
    w.source   = src;
    w.ts       = ts;
    w.oid      = oid;
    w.pay      = pay;
    return w;
  endfunction

  // Build the next word from predictor state: mostly keep every active source fed with
  // nondecreasing timestamps and pop, the rest is noise.
  function automatic req_t merge_word(int noise_pct);
    req_t           w;
    int             n;
    int             s;
    int             j;
    int             k;
    int             open_q[$];
    int             held_q[$];
    logic [TsW-1:0] inc;
    logic [TsW-1:0] ts_top;
    ts_top     = '1;
    n          = live_count();
    w.req_type = REQ_POP;
    w.source   = SrcW'($urandom_range(NumSrc - 1));
    w.ts       = {$urandom, $urandom};
    w.oid      = ($urandom_range(3) == 0) ? oid_corner[$urandom_range(2)] : OidW'($urandom);
    w.pay      = $urandom;
    for (int i = 0; i < n; i++) begin
      if (!held[i] && !closed[i]) open_q.push_back(i);
      if (held[i]) held_q.push_back(i);
    end
    if ($urandom_range(99) < noise_pct) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          w.req_type = REQ_OFFER;
          s = w.source;
          if (seen[s] && $urandom_range(3) != 0 && last_ts[s] > 1000)
            w.ts = last_ts[s] - $urandom_range(1000, 1);
        end
        4: begin
          w.req_type = REQ_OFFER;
          if (held_q.size() != 0) w.source = SrcW'(held_q[$urandom_range(held_q.size() - 1)]);
        end
        5, 6: w.req_type = REQ_POP;
        7: w.req_type = ReqUnused;
        default: begin
          // close a slot outside the active range: no effect on the merge
          if (n < NumSrc) begin
            w.req_type = REQ_CLOSE;
            w.source   = SrcW'($urandom_range(NumSrc - 1, n));
          end
        end
      endcase
    end else if (open_q.size() != 0) begin
      s = open_q[$urandom_range(open_q.size() - 1)];
      w.req_type = REQ_OFFER;
      w.source   = SrcW'(s);
      if (seen[s]) begin
        k = $urandom_range(19);
        j = (held_q.size() != 0) ? held_q[$urandom_range(held_q.size() - 1)] : s;
        if (k < 4 && held[j] && held_ts[j] >= last_ts[s]) begin
          // tie with another slot, sometimes on origin id too
          w.ts = held_ts[j];
          if (k < 2) w.oid = held_oid[j];
        end else if (k < 7) begin
          w.ts = last_ts[s];
        end else begin
          inc  = (k == 19) ? TsW'($urandom) : TsW'($urandom_range(5000, 1));
          w.ts = (last_ts[s] > ts_top - inc) ? ts_top : last_ts[s] + inc;
        end
      end
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(req_t w);
    while (gap_draw(req_gap_pct)) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.req_type     <= w.req_type;
    req_if.in_source    <= w.source;
    req_if.in_timestamp <= w.ts;
    req_if.in_origin_id <= w.oid;
    req_if.in_payload   <= w.pay;
    req_if.valid        <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (merge_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_active(logic [CfgW-1:0] value);
    settle();
    cfg_if.active_sources <= value;
    cfg_if.valid          <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(ReqUnused, 3'd7, '1, '1, '1));
    send_word(req_word(REQ_OFFER, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd0, 64'd5, 16'd1, 32'd1));
    send_word(req_word(REQ_OFFER, 3'd7, '1, '1, '1));
    write_active(4'd3);
    // slots 5 and 7 are outside the active range now
    send_word(req_word(REQ_OFFER, 3'd7, 64'd10, 16'd2, 32'h5a5a_a5a5));
    send_word(req_word(REQ_CLOSE, 3'd5, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd1, 64'd100, 16'd3, 32'h1111_0001));
    send_word(req_word(REQ_OFFER, 3'd2, 64'd100, 16'd3, 32'h2222_0002));
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd0, 64'd100, 16'd5, 32'h0000_0003));
    send_word(req_word(REQ_POP, 3'd4, '1, '1, '1));
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd1, 64'd99, 16'd3, 32'hdead_beef));
    send_word(req_word(REQ_OFFER, 3'd1, 64'd100, 16'd3, 32'h1111_0004));
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd1, 64'd200, 16'd0, 32'hffff_0000));
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
  endtask

  task automatic test_active_sweep();
    logic [CfgW-1:0] plan [11] = '{4'd5, 4'd2, 4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd4,
                                   4'd7, 4'd3, 4'd8};
    foreach (plan[p]) begin
      write_active(plan[p]);
      repeat (110) send_word(merge_word(15));
    end
  endtask

  task automatic test_back_to_back();
    req_gap_pct = 0;
    rsp_gap_pct = 0;
    write_active(4'd6);
    repeat (250) send_word(merge_word(10));
    req_gap_pct = 19;
    rsp_gap_pct = 19;
  endtask

  task automatic test_output_backpressure();
    write_active(4'd8);
    hold_ask = HoldOffLen;
    hold_serial++;
    // keep offering while the receiver holds off so the block backs up
    repeat (40) send_word(merge_word(10));
  endtask

  task automatic test_close_and_drain();
    int live_q[$];
    bit any_held;
    write_active(4'd8);
    repeat (NumSrc) begin
      repeat (8) send_word(merge_word(0));
      live_q.delete();
      for (int i = 0; i < NumSrc; i++)
        if (!closed[i]) live_q.push_back(i);
      send_word(req_word(REQ_CLOSE, SrcW'(live_q[$urandom_range(live_q.size() - 1)]),
                         '0, '0, '0));
    end
    // drain what is still buffered
    any_held = 1'b1;
    while (any_held) begin
      any_held = 1'b0;
      for (int i = 0; i < NumSrc; i++)
        if (held[i]) any_held = 1'b1;
      if (any_held) send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    end
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
    send_word(req_word(REQ_OFFER, 3'd3, '1, 16'h1234, 32'h0bad_cafe));
    send_word(req_word(REQ_CLOSE, 3'd3, '0, '0, '0));
    send_word(req_word(REQ_POP, 3'd6, '0, '0, '0));
    write_active(4'd3);
    send_word(req_word(REQ_POP, 3'd0, '0, '0, '0));
  endtask

  initial begin
    int missing;
    missing               = 0;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_OFFER;
    req_if.in_source      = '0;
    req_if.in_timestamp   = '0;
    req_if.in_origin_id   = '0;
    req_if.in_payload     = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.active_sources = ActiveReset;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_active_sweep();
    test_back_to_back();
    test_output_backpressure();
    test_close_and_drain();

    settle();
    missing = merge_rsp_q.size();
    if (missing != 0) $display("error: %0d response words never arrived", missing);
    $display("summary: %0d request words, %0d config writes (0 to 15), %0d-cycle hold-off",
             req_words, cfg_writes, HoldOffLen);
    $display("summary: %0d records out, %0d busy, %0d order errors, %0d waiting, %0d drained",
             status_hits[ST_RECORD], status_hits[ST_BUSY], status_hits[ST_DECREASE],
             status_hits[ST_WAITING], status_hits[ST_DRAINED]);
    if (fail_count == 0 && missing == 0) begin
      $display("timestamp_stream_merger_top regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("timestamp_stream_merger_top regression: fail");
    end
    $finish;
  end

endmodule
